### src/assert_macros.svh
// Assertion macros used by the top module of the BMP pixel row unpacker.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### src/bpru_pkg.sv
// Package of the BMP pixel row unpacker: types, codes and default sizes.
// No dependencies; imported by every module of the block.
package bpru_pkg;

    localparam int MAX_DIMENSION_DEF = 4096;
    localparam int PALETTE_DEPTH_DEF = 256;

    localparam int CFG_DIM_W = 13;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_PALETTE = 2'd1,
        ACT_DATA    = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        CFG_BPP       = 3'd0,
        CFG_WIDTH     = 3'd1,
        CFG_HEIGHT    = 3'd2,
        CFG_MIRROR_X  = 3'd3,
        CFG_BOTTOM_UP = 3'd4,
        CFG_OUT_FMT   = 3'd5
    } cfg_reg_idx_t;

    localparam logic [2:0] FMT_RGB555 = 3'd2;
    localparam logic [2:0] FMT_RGB24  = 3'd3;
    localparam logic [2:0] FMT_RGBA   = 3'd4;

    typedef struct packed {
        logic [5:0]           bpp;
        logic [CFG_DIM_W-1:0] width;
        logic [CFG_DIM_W-1:0] height;
        logic                 mirror_x;
        logic                 bottom_up;
        logic [2:0]           out_format;
    } cfg_t;

    // One pixel handed from the unpacking stage to the output register.
    typedef struct packed {
        logic        valid;
        logic [23:0] offset;
        logic [31:0] direct;
        logic        use_pal;
        logic        last;
        logic        done;
    } pix_t;

    typedef struct packed {
        logic        we;
        logic [7:0]  widx;
        logic [31:0] wdata;
        logic        re;
        logic [7:0]  ridx;
    } pal_req_t;

endpackage

### src/bmp_pixel_row_unpacker.sv
// An accepted item is held in the input register, and its pixels in the output register.
// Input transfers for depths of 8 bits and above are taken one per cycle while the output
// register can take a pixel; depths of 1, 2 and 4 bits give one pixel per cycle from each byte
// while it is free, so the single output register sets the pace. Palette items never wait on it.
// Reset (aresetn low, synchronous) clears the counters and handshakes and loads the default
// configuration; the data registers keep no reset; the palette memory keeps no reset and must be written before use.
module bmp_pixel_row_unpacker
    import bpru_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata from bit 0: palette_index[7:0], palette_entry[39:8], data_byte[47:40]
    input  logic [47:0] s_tdata,
    // tuser: action[1:0]
    input  logic [1:0]  s_tuser,
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata from bit 0: pixel_offset[23:0], pixel_value[55:24]
    output logic [55:0] m_tdata,
    // tlast: last_of_item
    output logic        m_tlast,
    // tuser: image_done
    output logic        m_tuser
);

    `include "assert_macros.svh"

    cfg_t        cfg_reg, cfg_next;
    pix_t        issue;
    pal_req_t    pal_req;
    logic [31:0] pal_rdata;
    logic        b_free;

    // Configuration is always taken; writes beyond the register list are dropped.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_reg_idx_t'(cfg_index))
                CFG_BPP:       cfg_next.bpp        = cfg_data[5:0];
                CFG_WIDTH:     cfg_next.width      = cfg_data;
                CFG_HEIGHT:    cfg_next.height     = cfg_data;
                CFG_MIRROR_X:  cfg_next.mirror_x   = cfg_data[0];
                CFG_BOTTOM_UP: cfg_next.bottom_up  = cfg_data[0];
                CFG_OUT_FMT:   cfg_next.out_format = cfg_data[2:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bpp        <= 6'd24;
            cfg_reg.width      <= 13'd1;
            cfg_reg.height     <= 13'd1;
            cfg_reg.mirror_x   <= 1'b0;
            cfg_reg.bottom_up  <= 1'b1;
            cfg_reg.out_format <= FMT_RGBA;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // The unpacking stage holds one input item and issues at most one pixel per
    // cycle into the output register, which acts as the skid between the sides.
    bpru_unpack #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_unpack (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_action        (s_tuser),
        .s_palette_index (s_tdata[7:0]),
        .s_palette_entry (s_tdata[39:8]),
        .s_data_byte     (s_tdata[47:40]),
        .b_free          (b_free),
        .issue           (issue),
        .pal_req         (pal_req)
    );

    // The palette read is registered at the same edge as the pixel it serves.
    bpru_palette #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk  (aclk),
        .req   (pal_req),
        .rdata (pal_rdata)
    );

    bpru_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .issue      (issue),
        .pal_rdata  (pal_rdata),
        .out_format (cfg_reg.out_format),
        .b_free     (b_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    // The final pixel of an image always closes the transfers of its byte.
    `ASSERT_IMPLY(a_done_is_last, aclk, aresetn, m_tvalid && m_tuser, m_tlast, "image_done without tlast")
    // A pixel is only issued when the output register can take it.
    `ASSERT_IMPLY(a_issue_room, aclk, aresetn, issue.valid, !m_tvalid || m_tready, "pixel issued over a held result")
    // A width write lands in the register in the following cycle.
    `ASSERT_NEXT(a_cfg_width, aclk, aresetn, cfg_valid && cfg_ready && cfg_index == CFG_WIDTH, cfg_reg.width == $past(cfg_data), "width register not written")
    // Palette writes and palette reads never share a cycle.
    `ASSERT_ALWAYS(a_pal_port, aclk, aresetn, !(pal_req.we && pal_req.re), "palette read and write in one cycle")

endmodule

### src/bpru_palette.sv
// Palette memory: one write port and one registered read port.
// Depends on bpru_pkg for the request structure.
module bpru_palette
    import bpru_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic        aclk,
    input  pal_req_t    req,
    output logic [31:0] rdata
);

    localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int RECIP  = 65536 / PALETTE_DEPTH;

    logic [31:0]       mem [PALETTE_DEPTH];
    logic [31:0]       rdata_reg;
    logic [PAL_AW-1:0] waddr;
    logic [PAL_AW-1:0] raddr;
    logic [23:0]       wq_prod;
    logic [23:0]       rq_prod;
    logic [8:0]        wrem;
    logic [8:0]        rrem;

    // Index modulo the depth: reciprocal estimate, then one correction step.
    always_comb begin
        wq_prod = 24'(req.widx) * 24'(RECIP);
        rq_prod = 24'(req.ridx) * 24'(RECIP);
        wrem    = 9'(req.widx) - 9'(wq_prod[23:16] * 9'(PALETTE_DEPTH));
        rrem    = 9'(req.ridx) - 9'(rq_prod[23:16] * 9'(PALETTE_DEPTH));
        if (wrem >= 9'(PALETTE_DEPTH)) begin
            wrem = wrem - 9'(PALETTE_DEPTH);
        end
        if (rrem >= 9'(PALETTE_DEPTH)) begin
            rrem = rrem - 9'(PALETTE_DEPTH);
        end
        waddr = wrem[PAL_AW-1:0];
        raddr = rrem[PAL_AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/bpru_unpack.sv
// Unpacking stage: input register, row and column counters, padding skip
// and pixel issue. Depends on bpru_pkg.
module bpru_unpack
    import bpru_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_palette_index,
    input  logic [31:0] s_palette_entry,
    input  logic [7:0]  s_data_byte,
    input  logic        b_free,
    output pix_t        issue,
    output pal_req_t    pal_req
);

    localparam int CNT_W = $clog2(MAX_DIMENSION);
    localparam int DW    = $clog2(MAX_DIMENSION + 1);
    localparam int CLW   = (DW > CFG_DIM_W) ? DW : CFG_DIM_W;

    logic             a_valid_reg,    a_valid_next;
    logic [1:0]       a_action_reg,   a_action_next;
    logic [7:0]       a_pidx_reg,     a_pidx_next;
    logic [31:0]      a_pent_reg,     a_pent_next;
    logic [7:0]       a_byte_reg,     a_byte_next;
    logic [2:0]       a_k_reg,        a_k_next;
    logic [23:0]      partial_reg,    partial_next;
    logic [1:0]       gathered_reg,   gathered_next;
    logic [CNT_W-1:0] column_reg,     column_next;
    logic [CNT_W-1:0] row_reg,        row_next;
    logic [1:0]       rbc_reg,        rbc_next;
    logic [1:0]       pad_reg,        pad_next;
    logic             finished_reg,   finished_next;

    logic             consume;
    logic             accept;
    logic             bpp_ok;
    logic             low_depth;
    logic [2:0]       need;
    logic             gather_full;
    logic [31:0]      full;
    logic [31:0]      high_bgra;
    logic [7:0]       pal_idx;
    logic             byte_last;
    logic [7:0]       byte_shifted;
    logic [CLW-1:0]   w_ext;
    logic [CLW-1:0]   h_ext;
    logic [DW-1:0]    w_dim;
    logic [DW-1:0]    h_dim;
    logic [23:0]      w24;
    logic [23:0]      h24;
    logic [23:0]      col24;
    logic [23:0]      row24;
    logic [23:0]      x24;
    logic [23:0]      y24;
    logic [47:0]      prod;
    logic             row_ended;
    logic             img_ended;

    always_comb begin
        w_ext = CLW'(cfg.width);
        h_ext = CLW'(cfg.height);
        if (w_ext == '0) begin
            w_dim = DW'(1);
        end else if (w_ext > CLW'(MAX_DIMENSION)) begin
            w_dim = DW'(MAX_DIMENSION);
        end else begin
            w_dim = DW'(w_ext);
        end
        if (h_ext == '0) begin
            h_dim = DW'(1);
        end else if (h_ext > CLW'(MAX_DIMENSION)) begin
            h_dim = DW'(MAX_DIMENSION);
        end else begin
            h_dim = DW'(h_ext);
        end
        w24   = 24'(w_dim);
        h24   = 24'(h_dim);
        col24 = 24'(column_reg);
        row24 = 24'(row_reg);
        x24   = cfg.mirror_x ? (w24 - 24'd1 - col24) : col24;
        y24   = cfg.bottom_up ? (h24 - 24'd1 - row24) : row24;
        prod  = y24 * w24;
        row_ended = (col24 + 24'd1) >= w24;
        img_ended = row_ended && ((row24 + 24'd1) >= h24);
    end

    always_comb begin
        bpp_ok    = 1'b0;
        low_depth = 1'b0;
        need      = 3'd4;
        pal_idx   = a_byte_reg;
        byte_last = 1'b1;
        byte_shifted = a_byte_reg;
        case (cfg.bpp) inside
            6'd1, 6'd2, 6'd4, 6'd8: begin
                bpp_ok    = 1'b1;
                low_depth = 1'b1;
            end
            6'd16, 6'd24, 6'd32: begin
                bpp_ok = 1'b1;
            end
            default: begin
                bpp_ok = 1'b0;
            end
        endcase
        case (cfg.bpp)
            6'd1: begin
                pal_idx      = {7'd0, a_byte_reg[7]};
                byte_last    = (a_k_reg == 3'd7);
                byte_shifted = {a_byte_reg[6:0], 1'b0};
            end
            6'd2: begin
                pal_idx      = {6'd0, a_byte_reg[7:6]};
                byte_last    = (a_k_reg == 3'd3);
                byte_shifted = {a_byte_reg[5:0], 2'd0};
            end
            6'd4: begin
                pal_idx      = {4'd0, a_byte_reg[7:4]};
                byte_last    = (a_k_reg == 3'd1);
                byte_shifted = {a_byte_reg[3:0], 4'd0};
            end
            6'd16: begin
                need = 3'd2;
            end
            6'd24: begin
                need = 3'd3;
            end
            default: begin
                need = 3'd4;
            end
        endcase
        full        = {8'd0, partial_reg} | (32'(a_byte_reg) << {gathered_reg, 3'b000});
        gather_full = ({1'b0, gathered_reg} + 3'd1) >= need;
        case (cfg.bpp)
            6'd16:   high_bgra = {8'd0, full[14:10], 3'd0, full[9:5], 3'd0, full[4:0], 3'd0};
            6'd24:   high_bgra = {8'd0, full[23:0]};
            default: high_bgra = full;
        endcase
    end

    always_comb begin
        consume       = 1'b0;
        issue         = '0;
        pal_req       = '0;
        a_byte_next   = a_byte_reg;
        a_k_next      = a_k_reg;
        partial_next  = partial_reg;
        gathered_next = gathered_reg;
        column_next   = column_reg;
        row_next      = row_reg;
        rbc_next      = rbc_reg;
        pad_next      = pad_reg;
        finished_next = finished_reg;

        pal_req.widx  = a_pidx_reg;
        pal_req.wdata = a_pent_reg;
        pal_req.ridx  = pal_idx;
        issue.offset  = 24'(x24 + prod[23:0]);
        issue.direct  = high_bgra;
        issue.use_pal = low_depth;
        issue.done    = img_ended;
        issue.last    = low_depth ? (byte_last || row_ended) : 1'b1;

        if (a_valid_reg) begin
            case (action_t'(a_action_reg))
                ACT_START: begin
                    consume       = 1'b1;
                    partial_next  = '0;
                    gathered_next = '0;
                    column_next   = '0;
                    row_next      = '0;
                    rbc_next      = '0;
                    pad_next      = '0;
                    finished_next = 1'b0;
                end
                ACT_PALETTE: begin
                    consume    = 1'b1;
                    pal_req.we = 1'b1;
                end
                ACT_DATA: begin
                    if (finished_reg || !bpp_ok) begin
                        consume = 1'b1;
                    end else if (pad_reg != 2'd0) begin
                        consume  = 1'b1;
                        pad_next = pad_reg - 2'd1;
                    end else if (!low_depth && !gather_full) begin
                        consume       = 1'b1;
                        partial_next  = full[23:0];
                        gathered_next = gathered_reg + 2'd1;
                        rbc_next      = rbc_reg + 2'd1;
                    end else if (b_free) begin
                        issue.valid = 1'b1;
                        pal_req.re  = low_depth;
                        if (row_ended) begin
                            column_next   = '0;
                            row_next      = row_reg + CNT_W'(1);
                            finished_next = img_ended;
                        end else begin
                            column_next = column_reg + CNT_W'(1);
                        end
                        if (issue.last) begin
                            consume = 1'b1;
                            if (!low_depth) begin
                                partial_next  = '0;
                                gathered_next = '0;
                            end
                            // The byte count of the row includes this byte.
                            if (row_ended) begin
                                pad_next = 2'd3 - rbc_reg;
                                rbc_next = '0;
                            end else begin
                                rbc_next = rbc_reg + 2'd1;
                            end
                        end else begin
                            a_k_next    = a_k_reg + 3'd1;
                            a_byte_next = byte_shifted;
                        end
                    end
                end
                default: begin
                    consume = 1'b1;
                end
            endcase
        end
    end

    assign s_tready = !a_valid_reg || consume;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        a_valid_next  = a_valid_reg && !consume;
        a_action_next = a_action_reg;
        a_pidx_next   = a_pidx_reg;
        a_pent_next   = a_pent_reg;
        if (accept) begin
            a_valid_next  = 1'b1;
            a_action_next = s_action;
            a_pidx_next   = s_palette_index;
            a_pent_next   = s_palette_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            a_k_reg      <= '0;
            partial_reg  <= '0;
            gathered_reg <= '0;
            column_reg   <= '0;
            row_reg      <= '0;
            rbc_reg      <= '0;
            pad_reg      <= '0;
            finished_reg <= 1'b0;
        end else begin
            a_valid_reg  <= a_valid_next;
            a_k_reg      <= accept ? 3'd0 : a_k_next;
            partial_reg  <= partial_next;
            gathered_reg <= gathered_next;
            column_reg   <= column_next;
            row_reg      <= row_next;
            rbc_reg      <= rbc_next;
            pad_reg      <= pad_next;
            finished_reg <= finished_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_action_reg <= a_action_next;
        a_pidx_reg   <= a_pidx_next;
        a_pent_reg   <= a_pent_next;
        a_byte_reg   <= accept ? s_data_byte : a_byte_next;
    end

endmodule

### src/bpru_out.sv
// Output register of the unpacker and colour packing into the output format.
// Depends on bpru_pkg; takes palette read data from bpru_palette.
module bpru_out
    import bpru_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  pix_t        issue,
    input  logic [31:0] pal_rdata,
    input  logic [2:0]  out_format,
    output logic        b_free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tuser
);

    logic        b_valid_reg, b_valid_next;
    pix_t        b_pix_reg;
    logic [31:0] bgra;
    logic [31:0] packed_val;

    assign b_free       = !b_valid_reg || m_tready;
    assign b_valid_next = issue.valid || (b_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue.valid) begin
            b_pix_reg <= issue;
        end
    end

    // Palette data arrives in the same cycle as the registered pixel.
    always_comb begin
        bgra = b_pix_reg.use_pal ? pal_rdata : b_pix_reg.direct;
        case (out_format)
            FMT_RGB555: packed_val = {17'd0, bgra[23:19], bgra[15:11], bgra[7:3]};
            FMT_RGB24:  packed_val = {8'd0, bgra[23:0]};
            FMT_RGBA:   packed_val = bgra;
            default:    packed_val = 32'd0;
        endcase
    end

    assign m_tvalid = b_valid_reg;
    assign m_tdata  = {packed_val, b_pix_reg.offset};
    assign m_tlast  = b_pix_reg.last;
    assign m_tuser  = b_pix_reg.done;

endmodule
